@@ rtl/t8tp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t8tp_pkg
// Types and constants shared by the twisted figure-eight torus point block.
// ----------------------------------------------------------------------------
package t8tp_pkg;

    localparam int T8_CORDIC_STEPS = 24;
    localparam int T8_CORDIC_LAT   = T8_CORDIC_STEPS + 2;
    localparam int T8_XY_W         = 34;
    localparam int T8_Z_W          = 33;
    localparam int T8_TRIG_W       = 18;
    localparam logic signed [T8_XY_W-1:0] T8_CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] T8_ATAN [0:T8_CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    localparam logic signed [15:0] T8_MAJOR_RST = 16'sd6144;
    localparam logic signed [15:0] T8_MINOR_RST = 16'sd2048;
    localparam logic T8_REG_MAJOR = 1'b0;
    localparam logic T8_REG_MINOR = 1'b1;

    typedef struct packed {
        logic [16:0] u_phase;
        logic [15:0] v_phase;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] du_x;
        logic signed [31:0] du_y;
        logic signed [31:0] du_z;
        logic signed [31:0] dv_x;
        logic signed [31:0] dv_y;
        logic signed [31:0] dv_z;
    } t_out_beat;

endpackage
`default_nettype wire

@@ rtl/twisted_eight_torus_point.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twisted_eight_torus_point
// Point and u/v tangents on a twisted figure-eight torus, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one (u, v)
//   phase pair per beat. Output channel (o_out_valid / i_out_stall /
//   o_out_data) gives position, d/du and sign(r)*d/dv, Q.OUT_FRAC_BITS,
//   rounded and saturated to 32 bits.
//   Radii are written over the APB port (0x0 major, 0x4 minor, Q4.12) while
//   the pipe is empty; pready is tied high.
//   Throughput: one beat per cycle while the output is not stalled. From
//   input accept to output valid a beat passes the 24-step CORDIC pipes (26
//   register stages) and six multiply / round stages.
//   Reset clears the valid bits and loads the default radii.
//   While the output beat is stalled the whole pipe holds and o_in_stall is
//   raised; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module twisted_eight_torus_point
    import t8tp_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_beat    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_beat        o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PIPE_DEPTH = T8_CORDIC_LAT + 6;
    localparam int SH_P  = 44 - OUT_FRAC_BITS;
    localparam int SH_DU = 45 - OUT_FRAC_BITS;
    localparam int SH_DV = 32 - OUT_FRAC_BITS;

    function automatic logic signed [31:0] emit(input logic signed [63:0] v, input int s);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (t > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (t < -64'sd2147483648)
            return 32'sh80000000;
        else
            return t[31:0];
    endfunction

    // config
    logic signed [15:0] r_major, r_minor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major <= T8_MAJOR_RST;
            r_minor <= T8_MINOR_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == T8_REG_MAJOR) r_major <= pwdata[15:0];
            else                          r_minor <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == T8_REG_MINOR) ? 32'(r_minor) : 32'(r_major);

    // flow control
    logic                  en;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign en          = !(r_vld[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    // trig
    logic signed [T8_TRIG_W-1:0] w_cu, w_su, w_cu2, w_su2, w_cv, w_sv, w_c2v, w_s2v;

    t8tp_cordic u_trig_u (
        .i_clk(i_clk), .i_en(en), .i_phase({i_in_data.u_phase[15:0], 16'b0}),
        .o_cos(w_cu), .o_sin(w_su)
    );
    t8tp_cordic u_trig_u2 (
        .i_clk(i_clk), .i_en(en), .i_phase({i_in_data.u_phase, 15'b0}),
        .o_cos(w_cu2), .o_sin(w_su2)
    );
    t8tp_cordic u_trig_v (
        .i_clk(i_clk), .i_en(en), .i_phase({i_in_data.v_phase, 16'b0}),
        .o_cos(w_cv), .o_sin(w_sv)
    );
    t8tp_cordic u_trig_v2 (
        .i_clk(i_clk), .i_en(en), .i_phase({i_in_data.v_phase[14:0], 17'b0}),
        .o_cos(w_c2v), .o_sin(w_s2v)
    );

    // stage 1: trig products
    logic signed [35:0] m_a0, m_a1, m_b0, m_b1, m_c0, m_c1, m_d0, m_d1;
    assign m_a0 = w_cu2 * w_sv;
    assign m_a1 = w_su2 * w_s2v;
    assign m_b0 = w_su2 * w_sv;
    assign m_b1 = w_cu2 * w_s2v;
    assign m_c0 = w_cv * w_cu2;
    assign m_c1 = w_c2v * w_su2;
    assign m_d0 = w_cv * w_su2;
    assign m_d1 = w_cu2 * w_c2v;

    logic signed [36:0] r1_a, r1_b;
    logic signed [37:0] r1_cqp, r1_dvzp;
    logic signed [T8_TRIG_W-1:0] r1_cu, r1_su;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a    <= 37'(m_a0) - 37'(m_a1);
            r1_b    <= 37'(m_b0) + 37'(m_b1);
            r1_cqp  <= 38'(m_c0) - (38'(m_c1) <<< 1);
            r1_dvzp <= 38'(m_d0) + (38'(m_d1) <<< 1);
            r1_cu   <= w_cu;
            r1_su   <= w_su;
        end
    end

    // stage 2: minor radius products, sign(r)
    logic               w_pos, w_neg;
    logic signed [37:0] w_cqt;
    logic signed [21:0] w_cq;
    logic signed [22:0] n2_cqs;
    logic signed [38:0] n2_dvz;

    assign w_pos = (r_minor > 16'sd0);
    assign w_neg = r_minor[15];
    assign w_cqt = (r1_cqp + 38'sd32768) >>> 16;
    assign w_cq  = w_cqt[21:0];

    always_comb begin
        if (w_pos) begin
            n2_cqs = 23'(w_cq);
            n2_dvz = 39'(r1_dvzp);
        end else if (w_neg) begin
            n2_cqs = -23'(w_cq);
            n2_dvz = -39'(r1_dvzp);
        end else begin
            n2_cqs = '0;
            n2_dvz = '0;
        end
    end

    logic signed [52:0] r2_ra, r2_rb;
    logic signed [22:0] r2_cqs;
    logic signed [38:0] r2_dvz;
    logic signed [T8_TRIG_W-1:0] r2_cu, r2_su;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ra  <= r1_a * r_minor;
            r2_rb  <= r1_b * r_minor;
            r2_cqs <= n2_cqs;
            r2_dvz <= n2_dvz;
            r2_cu  <= r1_cu;
            r2_su  <= r1_su;
        end
    end

    // stage 3: F and u factor rounded to Q.28, v tangents x/y
    logic signed [53:0] w_fsum, w_usum;
    assign w_fsum = ((54'(r_major) <<< 32) + 54'(r2_ra) + 54'sd32768) >>> 16;
    assign w_usum = (54'(r2_rb) + 54'sd32768) >>> 16;

    logic signed [37:0] r3_fac, r3_ud;
    logic signed [52:0] r3_pz, r3_duz;
    logic signed [40:0] r3_dvx, r3_dvy;
    logic signed [38:0] r3_dvz;
    logic signed [T8_TRIG_W-1:0] r3_cu, r3_su;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_fac <= w_fsum[37:0];
            r3_ud  <= w_usum[37:0];
            r3_pz  <= r2_rb;
            r3_duz <= r2_ra;
            r3_dvx <= r2_cu * r2_cqs;
            r3_dvy <= r2_su * r2_cqs;
            r3_dvz <= r2_dvz;
            r3_cu  <= r2_cu;
            r3_su  <= r2_su;
        end
    end

    // stage 4: position and u-factor products
    logic signed [55:0] r4_px, r4_py, r4_cuud, r4_suud;
    logic signed [52:0] r4_pz, r4_duz;
    logic signed [40:0] r4_dvx, r4_dvy;
    logic signed [38:0] r4_dvz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_px   <= r3_fac * r3_cu;
            r4_py   <= r3_fac * r3_su;
            r4_cuud <= r3_cu * r3_ud;
            r4_suud <= r3_su * r3_ud;
            r4_pz   <= r3_pz;
            r4_duz  <= r3_duz;
            r4_dvx  <= r3_dvx;
            r4_dvy  <= r3_dvy;
            r4_dvz  <= r3_dvz;
        end
    end

    // stage 5: u tangent x/y
    logic signed [57:0] r5_dux, r5_duy;
    logic signed [55:0] r5_px, r5_py;
    logic signed [52:0] r5_pz, r5_duz;
    logic signed [40:0] r5_dvx, r5_dvy;
    logic signed [38:0] r5_dvz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dux <= -58'(r4_cuud) - (58'(r4_py) <<< 1);
            r5_duy <= -58'(r4_suud) + (58'(r4_px) <<< 1);
            r5_px  <= r4_px;
            r5_py  <= r4_py;
            r5_pz  <= r4_pz;
            r5_duz <= r4_duz;
            r5_dvx <= r4_dvx;
            r5_dvy <= r4_dvy;
            r5_dvz <= r4_dvz;
        end
    end

    // stage 6: round and saturate into the output register
    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pos_x <= emit(64'(r5_px), SH_P);
            r_out.pos_y <= emit(64'(r5_py), SH_P);
            r_out.pos_z <= emit(64'(r5_pz), SH_P);
            r_out.du_x  <= emit(64'(r5_dux), SH_DU);
            r_out.du_y  <= emit(64'(r5_duy), SH_DU);
            r_out.du_z  <= emit(64'(r5_duz), SH_DU);
            r_out.dv_x  <= emit(64'(r5_dvx), SH_DV);
            r_out.dv_y  <= emit(64'(r5_dvy), SH_DV);
            r_out.dv_z  <= emit(64'(r5_dvz), SH_DV);
        end
    end

    assign o_out_data = r_out;

endmodule
`default_nettype wire

@@ rtl/t8tp_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t8tp_cordic
// Pipelined rotation CORDIC: 32-bit turn phase in, Q.16 cosine and sine out.
// ----------------------------------------------------------------------------
module t8tp_cordic
    import t8tp_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [31:0]                 i_phase,
    output logic signed [T8_TRIG_W-1:0]      o_cos,
    output logic signed [T8_TRIG_W-1:0]      o_sin
);

    localparam logic [1:0] QD_0 = 2'd0;
    localparam logic [1:0] QD_1 = 2'd1;
    localparam logic [1:0] QD_2 = 2'd2;

    logic signed [T8_XY_W-1:0] r_x [0:T8_CORDIC_STEPS];
    logic signed [T8_XY_W-1:0] r_y [0:T8_CORDIC_STEPS];
    logic signed [T8_Z_W-1:0]  r_z [0:T8_CORDIC_STEPS];
    logic [1:0]                r_q [0:T8_CORDIC_STEPS];
    logic signed [T8_TRIG_W-1:0] r_cos, r_sin;
    logic signed [T8_TRIG_W-1:0] n_cos, n_sin, c0, s0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= T8_CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= $signed({3'b000, i_phase[29:0]});
            r_q[0] <= i_phase[31:30];
        end
    end

    for (genvar i = 0; i < T8_CORDIC_STEPS; i++) begin : g_step
        logic signed [T8_Z_W-1:0] w_atan;
        assign w_atan = $signed({1'b0, T8_ATAN[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - w_atan;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + w_atan;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    logic signed [T8_XY_W-1:0] w_xr, w_yr;
    assign w_xr = (r_x[T8_CORDIC_STEPS] + 34'sd8192) >>> 14;
    assign w_yr = (r_y[T8_CORDIC_STEPS] + 34'sd8192) >>> 14;
    assign c0 = w_xr[T8_TRIG_W-1:0];
    assign s0 = w_yr[T8_TRIG_W-1:0];

    always_comb begin
        case (r_q[T8_CORDIC_STEPS])
            QD_0: begin
                n_cos = c0;
                n_sin = s0;
            end
            QD_1: begin
                n_cos = -s0;
                n_sin = c0;
            end
            QD_2: begin
                n_cos = -c0;
                n_sin = -s0;
            end
            default: begin
                n_cos = s0;
                n_sin = -c0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
`default_nettype wire

@@ rtl/t8tp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t8tp_checker
// Port-level checks for the torus point block, bound to the top level.
// ----------------------------------------------------------------------------
module t8tp_checker
    import t8tp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_beat   o_out_data,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == 3'd4 ##1 psel && !pwrite && paddr == 3'd4
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("minor radius read-back mismatch");

endmodule

bind twisted_eight_torus_point t8tp_checker u_t8tp_checker (.*);
`default_nettype wire

@@ verif/tb_twisted_eight_torus_point.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_twisted_eight_torus_point
// Self-checking bench for the twisted figure-eight torus point block.
// A local bit-true model predicts position and both tangents per (u, v) beat;
// results are compared in order, field by field, under random bursts, gaps
// and output stalls, across several radius settings written over APB.
// ----------------------------------------------------------------------------
module tb_twisted_eight_torus_point;
    import t8tp_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_LAT = 32;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in_beat i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out_beat o_out_data;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    twisted_eight_torus_point #(.OUT_FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic signed [15:0] major_r;
    logic signed [15:0] minor_r;
    t_out_beat surface_q[$];
    int errors;
    int beats_sent;
    int beats_checked;
    int stall_pct;
    int gap_max;
    bit hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** twisted_eight_torus_point: FAILED **");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    task automatic cordic(input logic [31:0] ph, output longint c, output longint s);
        longint x, y, z, nx, c0, s0;
        logic [1:0] q;
        q = ph[31:30];
        z = longint'(ph[29:0]);
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z -= longint'(T8_ATAN[i]);
            end else begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z += longint'(T8_ATAN[i]);
            end
            x = nx;
        end
        c0 = rnd(x, 14);
        s0 = rnd(y, 14);
        case (q)
            2'd0: begin c = c0; s = s0; end
            2'd1: begin c = -s0; s = c0; end
            2'd2: begin c = -c0; s = -s0; end
            default: begin c = s0; s = -c0; end
        endcase
    endtask

    function automatic logic signed [31:0] sat_out(longint v, int frac);
        longint r;
        r = rnd(v, frac - FRAC);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic surface_point(input t_in_beat b, output t_out_beat o);
        longint cu, su, cu2, su2, cv, sv, c2v, s2v;
        longint rr, rm, sg, a, bb, fac, px, py, ud, cq;
        logic [31:0] pu, pu2, pv, p2v;
        pu = {b.u_phase[15:0], 16'd0};
        pu2 = {b.u_phase, 15'd0};
        pv = {b.v_phase, 16'd0};
        p2v = {b.v_phase[14:0], 17'd0};
        cordic(pu, cu, su);
        cordic(pu2, cu2, su2);
        cordic(pv, cv, sv);
        cordic(p2v, c2v, s2v);
        rr = longint'(major_r);
        rm = longint'(minor_r);
        a = cu2 * sv - su2 * s2v;
        bb = su2 * sv + cu2 * s2v;
        fac = rnd(rr * 64'sd4294967296 + rm * a, 16);
        px = fac * cu;
        py = fac * su;
        ud = rnd(rm * bb, 16);
        sg = (rm > 0) ? 1 : (rm < 0) ? -1 : 0;
        cq = rnd(cv * cu2 - 2 * c2v * su2, 16);
        o.pos_x = sat_out(px, 44);
        o.pos_y = sat_out(py, 44);
        o.pos_z = sat_out(rm * bb, 44);
        o.du_x = sat_out(-(cu * ud) - 2 * py, 45);
        o.du_y = sat_out(-(su * ud) + 2 * px, 45);
        o.du_z = sat_out(rm * a, 45);
        o.dv_x = sat_out(sg * cu * cq, 32);
        o.dv_y = sat_out(sg * su * cq, 32);
        o.dv_z = sat_out(sg * (cv * su2 + 2 * cu2 * c2v), 32);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: got %0d want %0d (beat %0d)", what,
                     $signed(got), $signed(want), beats_checked);
    endtask

    // output checker and stall pattern
    always @(posedge i_clk) begin
        t_out_beat w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (surface_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_out_data.pos_x, '0);
                end else begin
                    w = surface_q.pop_front();
                    if (o_out_data.pos_x !== w.pos_x) report_mismatch("pos_x", o_out_data.pos_x, w.pos_x);
                    if (o_out_data.pos_y !== w.pos_y) report_mismatch("pos_y", o_out_data.pos_y, w.pos_y);
                    if (o_out_data.pos_z !== w.pos_z) report_mismatch("pos_z", o_out_data.pos_z, w.pos_z);
                    if (o_out_data.du_x !== w.du_x) report_mismatch("du_x", o_out_data.du_x, w.du_x);
                    if (o_out_data.du_y !== w.du_y) report_mismatch("du_y", o_out_data.du_y, w.du_y);
                    if (o_out_data.du_z !== w.du_z) report_mismatch("du_z", o_out_data.du_z, w.du_z);
                    if (o_out_data.dv_x !== w.dv_x) report_mismatch("dv_x", o_out_data.dv_x, w.dv_x);
                    if (o_out_data.dv_y !== w.dv_y) report_mismatch("dv_y", o_out_data.dv_y, w.dv_y);
                    if (o_out_data.dv_z !== w.dv_z) report_mismatch("dv_z", o_out_data.dv_z, w.dv_z);
                    beats_checked++;
                end
            end
            i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_beat(input t_in_beat b);
        t_out_beat o;
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        surface_point(b, o);
        surface_q.push_back(o);
        beats_sent++;
        if (gap_max > 0 && $urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(gap_max, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (surface_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic reg_sel, input logic signed [15:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {{16{val[15]}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == T8_REG_MAJOR) major_r = val;
        else minor_r = val;
    endtask

    task automatic set_radii(input logic signed [15:0] rmaj, input logic signed [15:0] rmin);
        drain();
        write_radius(T8_REG_MAJOR, rmaj);
        write_radius(T8_REG_MINOR, rmin);
    endtask

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.u_phase = 17'($urandom);
        b.v_phase = 16'($urandom);
        return b;
    endfunction

    task automatic test_directed_points();
        t_in_beat b;
        logic [16:0] us[6] = '{17'h00000, 17'h1FFFF, 17'h08000, 17'h10000, 17'h0AAAA, 17'h15555};
        logic [15:0] vs[4] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000};
        foreach (us[i]) begin
            foreach (vs[j]) begin
                if ((i + j) % 2 == 0 || i < 2) begin
                    b.u_phase = us[i];
                    b.v_phase = vs[j];
                    send_beat(b);
                end
            end
        end
    endtask

    task automatic test_random_stream(input int n);
        for (int k = 0; k < n; k++) send_beat(rand_beat());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (120) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random_stream(60);
        join
        drain();
    endtask

    initial begin
        errors = 0;
        beats_sent = 0;
        beats_checked = 0;
        stall_pct = 0;
        gap_max = 0;
        hold_off = 1'b0;
        major_r = T8_MAJOR_RST;
        minor_r = T8_MINOR_RST;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_points();
        stall_pct = 30;
        gap_max = 4;
        test_random_stream(150);
        set_radii(16'sh7FFF, 16'sh7FFF);
        test_directed_points();
        test_random_stream(100);
        set_radii(-16'sh8000, -16'sh8000);
        test_random_stream(100);
        set_radii(16'sd4096, 16'sd0);
        test_random_stream(80);
        set_radii(-16'sd3000, -16'sd1);
        stall_pct = 0;
        gap_max = 0;
        test_random_stream(100);
        test_backpressure();
        stall_pct = 60;
        gap_max = 10;
        for (int p = 0; p < 4; p++) begin
            set_radii(16'($urandom), 16'($urandom));
            test_random_stream(50);
        end
        drain();

        $display("covered %0d beats, %0d checked, over 7+ radius settings incl. extremes",
                 beats_sent, beats_checked);
        if (errors == 0) begin
            $display("** twisted_eight_torus_point: PASSED **");
        end else begin
            $display("** twisted_eight_torus_point: FAILED **");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/t8tp_pkg.sv
rtl/t8tp_cordic.sv
rtl/twisted_eight_torus_point.sv
rtl/t8tp_checker.sv
verif/tb_twisted_eight_torus_point.sv
